FILE: hw/rtl/srsb_pkg.sv
`timescale 1ns / 1ps
package srsb_pkg;

    localparam int DEPTH_DEF = 64;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_NEXT  = 3'd1;
    localparam logic [2:0] OP_MARK  = 3'd2;
    localparam logic [2:0] OP_CLEAR = 3'd3;
    localparam logic [2:0] OP_STATS = 3'd4;

    // cell commands
    localparam logic [2:0] MODE_HOLD      = 3'd0;
    localparam logic [2:0] MODE_ROTATE    = 3'd1;
    localparam logic [2:0] MODE_KILL      = 3'd2;
    localparam logic [2:0] MODE_SWAP_EVEN = 3'd3;
    localparam logic [2:0] MODE_SWAP_ODD  = 3'd4;
    localparam logic [2:0] MODE_UNSYNC    = 3'd5;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] ph;
        logic [31:0] ec;
        logic [31:0] temp;
        logic        synced;
    } rec_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] stamp;
        logic [31:0] ph_word;
        logic [31:0] ec_word;
        logic [31:0] temp_word;
    } in_word_t;

    typedef struct packed {
        logic        found;
        logic [31:0] out_stamp;
        logic [31:0] out_ph;
        logic [31:0] out_ec;
        logic [31:0] out_temp;
        logic [6:0]  total_count;
        logic [6:0]  marked_count;
        logic [6:0]  pending_count;
        logic [6:0]  cleared_count;
    } out_word_t;

endpackage

FILE: hw/rtl/srsb_if.sv
`timescale 1ns / 1ps
interface srsb_in_if;
    import srsb_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface srsb_out_if;
    import srsb_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/srsb_cell.sv
`timescale 1ns / 1ps
module srsb_cell #(
    parameter int DEPTH = srsb_pkg::DEPTH_DEF,
    parameter int IDX   = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [2:0]                 mode,
    input  logic [$clog2(DEPTH+1)-1:0] held,
    input  srsb_pkg::rec_t             left_rec,
    input  srsb_pkg::rec_t             right_rec,
    output srsb_pkg::rec_t             rec
);
    import srsb_pkg::*;

    localparam int HW = $clog2(DEPTH + 1);
    localparam logic [HW-1:0] IDX_V = HW'(IDX);
    localparam logic EVEN_IDX  = ((IDX % 2) == 0);
    localparam logic HAS_RIGHT = ((IDX + 1) < DEPTH);
    localparam logic HAS_LEFT  = (IDX > 0);

    rec_t rec_reg;
    rec_t rec_next;
    logic lead;

    always_comb
    begin
        rec_next = rec_reg;
        // left member of the pair in this exchange round
        lead = EVEN_IDX ^ (mode == MODE_SWAP_ODD);
        unique case (mode)
            MODE_HOLD:
            begin
                rec_next = rec_reg;
            end
            MODE_ROTATE:
            begin
                rec_next = right_rec;
            end
            MODE_KILL:
            begin
                // dead slots become zero with the flag set as a drop mark
                if (rec_reg.synced || (IDX_V >= held))
                begin
                    rec_next = '0;
                    rec_next.synced = 1'b1;
                end
            end
            MODE_SWAP_EVEN, MODE_SWAP_ODD:
            begin
                if (lead)
                begin
                    if (HAS_RIGHT && rec_reg.synced && !right_rec.synced)
                    begin
                        rec_next = right_rec;
                    end
                end
                else if (HAS_LEFT && left_rec.synced && !rec_reg.synced)
                begin
                    rec_next = left_rec;
                end
            end
            MODE_UNSYNC:
            begin
                rec_next.synced = 1'b0;
            end
            default:
            begin
                rec_next = rec_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_reg <= '0;
        end
        else
        begin
            rec_reg <= rec_next;
        end
    end

    assign rec = rec_reg;

endmodule

FILE: hw/rtl/sample_record_sync_buffer_unit.sv
`timescale 1ns / 1ps
// Add, get next, mark, stats: the ring of record cells rotates once through the head cell,
// which is searched and updated, before the result word is built.
// Clear synced: DEPTH odd-even exchange rounds compact the cells.
// One item in flight: a new item is taken only once the previous one is done, and it is
// taken while the previous result waits.
// Reset (asynchronous, active low) zeroes every cell, the write pointer and all counts at once.
module sample_record_sync_buffer_unit #(
    parameter int DEPTH = srsb_pkg::DEPTH_DEF
) (
    input logic         clk,
    input logic         rst_n,
    srsb_in_if.sink     req,
    srsb_out_if.source  rsp
);
    import srsb_pkg::*;

    localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] LAST = CW'(DEPTH - 1);
    localparam logic [HW-1:0] FULL = HW'(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RUN    = 3'd1;
    localparam logic [2:0] S_KILL   = 3'd2;
    localparam logic [2:0] S_SWAP   = 3'd3;
    localparam logic [2:0] S_UNSYNC = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    in_word_t      word_reg, word_next;
    logic [CW-1:0] wslot_reg, wslot_next;
    logic [CW-1:0] wptr_reg, wptr_next;
    logic [HW-1:0] held_reg, held_next;
    logic [HW-1:0] synced_reg, synced_next;
    logic [HW-1:0] acc_reg, acc_next;
    logic [HW-1:0] cleared_reg, cleared_next;
    logic          done_reg, done_next;
    logic          found_reg, found_next;
    rec_t          frec_reg, frec_next;
    out_word_t     out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic [2:0] cell_mode;
    rec_t       head;
    rec_t       fb;
    logic       in_held;
    rec_t       cell_q   [DEPTH];
    rec_t       left_in  [DEPTH];
    rec_t       right_in [DEPTH];

    assign head    = cell_q[0];
    assign in_held = (HW'(cnt_reg) < held_reg);

    always_comb
    begin
        unique case (state_reg)
            S_RUN:    cell_mode = MODE_ROTATE;
            S_KILL:   cell_mode = MODE_KILL;
            S_SWAP:   cell_mode = cnt_reg[0] ? MODE_SWAP_ODD : MODE_SWAP_EVEN;
            S_UNSYNC: cell_mode = MODE_UNSYNC;
            default:  cell_mode = MODE_HOLD;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        word_next      = word_reg;
        wslot_next     = wslot_reg;
        wptr_next      = wptr_reg;
        held_next      = held_reg;
        synced_next    = synced_reg;
        acc_next       = acc_reg;
        cleared_next   = cleared_reg;
        done_next      = done_reg;
        found_next     = found_reg;
        frec_next      = frec_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        fb             = head;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    word_next    = req.payload;
                    cnt_next     = '0;
                    done_next    = 1'b0;
                    found_next   = 1'b0;
                    frec_next    = '0;
                    cleared_next = '0;
                    acc_next     = '0;
                    state_next   = S_RUN;
                    if (req.payload.opcode == OP_ADD)
                    begin
                        // overwrite the oldest slot once full
                        wslot_next = wptr_reg;
                        wptr_next  = (wptr_reg == LAST) ? '0 : wptr_reg + 1'b1;
                        if (held_reg != FULL)
                        begin
                            held_next = held_reg + 1'b1;
                        end
                    end
                    else if (req.payload.opcode == OP_CLEAR)
                    begin
                        cleared_next = synced_reg;
                        state_next   = S_KILL;
                    end
                end
            end
            S_RUN:
            begin
                case (word_reg.opcode)
                    OP_ADD:
                    begin
                        if (cnt_reg == wslot_reg)
                        begin
                            fb.stamp  = word_reg.stamp;
                            fb.ph     = word_reg.ph_word;
                            fb.ec     = word_reg.ec_word;
                            fb.temp   = word_reg.temp_word;
                            fb.synced = 1'b0;
                        end
                    end
                    OP_NEXT:
                    begin
                        if (!done_reg && in_held && !head.synced && (head.stamp != '0))
                        begin
                            found_next = 1'b1;
                            frec_next  = head;
                            done_next  = 1'b1;
                        end
                    end
                    OP_MARK:
                    begin
                        if (!done_reg && in_held && (head.stamp == word_reg.stamp))
                        begin
                            fb.synced = 1'b1;
                            done_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        fb = head;
                    end
                endcase
                if (in_held && fb.synced)
                begin
                    acc_next = acc_reg + 1'b1;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    synced_next = acc_next;
                    state_next  = S_EMIT;
                end
            end
            S_KILL:
            begin
                held_next   = held_reg - synced_reg;
                wptr_next   = (held_next == FULL) ? '0 : CW'(held_next);
                synced_next = '0;
                cnt_next    = '0;
                state_next  = S_SWAP;
            end
            S_SWAP:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    state_next = S_UNSYNC;
                end
            end
            S_UNSYNC:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next.found         = found_reg;
                    out_next.out_stamp     = frec_reg.stamp;
                    out_next.out_ph        = frec_reg.ph;
                    out_next.out_ec        = frec_reg.ec;
                    out_next.out_temp      = frec_reg.temp;
                    out_next.total_count   = 7'(held_reg);
                    out_next.marked_count  = 7'(synced_reg);
                    out_next.pending_count = 7'(held_reg - synced_reg);
                    out_next.cleared_count = 7'(cleared_reg);
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            wptr_reg      <= '0;
            held_reg      <= '0;
            synced_reg    <= '0;
            acc_reg       <= '0;
            cleared_reg   <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wptr_reg      <= wptr_next;
            held_reg      <= held_next;
            synced_reg    <= synced_next;
            acc_reg       <= acc_next;
            cleared_reg   <= cleared_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        wslot_reg <= wslot_next;
        frec_reg  <= frec_next;
        out_reg   <= out_next;
    end

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            assign left_in[k] = cell_q[k];
        end
        else
        begin : g_mid_l
            assign left_in[k] = cell_q[k-1];
        end
        // last cell takes the updated head word on rotation
        if (k == DEPTH - 1)
        begin : g_last
            assign right_in[k] = fb;
        end
        else
        begin : g_mid_r
            assign right_in[k] = cell_q[k+1];
        end
        srsb_cell #(
            .DEPTH (DEPTH),
            .IDX   (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .mode      (cell_mode),
            .held      (held_reg),
            .left_rec  (left_in[k]),
            .right_rec (right_in[k]),
            .rec       (cell_q[k])
        );
    end

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    a_synced_le_held: assert property (@(posedge clk) disable iff (!rst_n)
        synced_reg <= held_reg)
        else $error("synced count above held count");

    a_held_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= FULL)
        else $error("held count above depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("new word taken while one is in progress");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready) |=> rsp.valid)
        else $error("result word not presented");

endmodule
